@@ hdl/integer_matrix_multiply_unit_defines.svh @@
// Assertion helpers used by the RTL of integer_matrix_multiply_unit.
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define IMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imm assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define IMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imm assertion failed");

`endif

@@ hdl/imm_pkg.sv @@
package imm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DIM_LIMIT   = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ADDR_CALC_W = 10;

    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int ELEM_W = 16;
    localparam int SUM_W  = 32;

    localparam logic [1:0] OP_WR_FIRST  = 2'd0;
    localparam logic [1:0] OP_WR_SECOND = 2'd1;
    localparam logic [1:0] OP_MULTIPLY  = 2'd2;

    localparam logic [1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [1:0] REG_INNER_DIM   = 2'd1;
    localparam logic [1:0] REG_COLS_SECOND = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } imm_tag_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] value;
        logic             last;
    } imm_result_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] v;
        v = r;
        if (r == '0) begin
            v = DIM_W'(1);
        end else if (r > DIM_W'(DIM_LIMIT)) begin
            v = DIM_W'(DIM_LIMIT);
        end
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] t;
        t = eff_dim(r) - DIM_W'(1);
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        logic [ADDR_CALC_W-1:0] a;
        a = ADDR_CALC_W'(row) * ADDR_CALC_W'(MAX_DIM) + ADDR_CALC_W'(col);
        return a[ADDR_W-1:0];
    endfunction

endpackage

@@ hdl/imm_mac.sv @@
module imm_mac import imm_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  imm_tag_t                 tag_in,
    input  logic signed [ELEM_W-1:0] a_data,
    input  logic signed [ELEM_W-1:0] b_data,
    output imm_result_t              res
);

    imm_tag_t          tag_reg;
    logic [SUM_W-1:0]  prod_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  acc_next;
    logic signed [SUM_W-1:0] prod;

    assign prod = a_data * b_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.valid <= 1'b0;
        end else if (adv) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod;
            if (tag_reg.valid) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign acc_next = tag_reg.first ? prod_reg : acc_reg + prod_reg;

    always_comb begin
        res.valid = tag_reg.valid && tag_reg.last_k;
        res.row   = tag_reg.row;
        res.col   = tag_reg.col;
        res.value = acc_next;
        res.last  = tag_reg.last;
    end

endmodule

@@ hdl/integer_matrix_multiply_unit.sv @@
// Integer matrix multiplier. Words on the s_ side write one signed 16-bit element of
// matrix A or B (one per cycle, sustained while no multiply runs) or start a multiply.
// A multiply walks rows x cols x inner products through a single multiply-accumulate
// unit, one product per cycle while the output is not stalled: s_tready stays low for
// the whole walk, and after the walk ends the last word still passes through the
// product and output registers. The walk reads one entry of each store per cycle,
// which sets that rate. Results leave row-major with m_tlast on the final one; a
// stall on m_tready while a word is waiting freezes the whole walk. Sums wrap at 32
// bits. Sizes are clamped to 1..8, writes outside them are dropped. The stores are
// not cleared: read only entries already written.
`include "integer_matrix_multiply_unit_defines.svh"

module integer_matrix_multiply_unit import imm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[21:6]
    input  logic [1:0]  s_tuser,   // operation[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6]
    output logic        m_tlast
);

    logic [DIM_W-1:0] rows_first_reg, inner_dim_reg, cols_second_reg;
    logic [IDX_W-1:0] nr_m1, nk_m1, nc_m1;
    logic [DIM_W-1:0] nr, nk, nc;

    logic [1:0]        in_op;
    logic [IDX_W-1:0]  in_row, in_col;
    logic [ELEM_W-1:0] in_val;
    logic              in_accept;
    logic              wr_a, wr_b, start;

    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  i_reg, j_reg, k_reg, i_next, j_next, k_next;
    logic              adv, issue, k_end, j_end, i_end;

    logic [ELEM_W-1:0] first_mem  [STORE_DEPTH];
    logic [ELEM_W-1:0] second_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    imm_tag_t    s1_tag_reg;
    imm_result_t res;

    logic              m_tvalid_reg, m_tlast_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [SUM_W-1:0]  out_val_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_first_reg  <= DIM_W'(8);
            inner_dim_reg   <= DIM_W'(8);
            cols_second_reg <= DIM_W'(8);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS_FIRST:  rows_first_reg  <= cfg_wdata;
                REG_INNER_DIM:   inner_dim_reg   <= cfg_wdata;
                REG_COLS_SECOND: cols_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign nr    = eff_dim(rows_first_reg);
    assign nk    = eff_dim(inner_dim_reg);
    assign nc    = eff_dim(cols_second_reg);
    assign nr_m1 = last_idx(rows_first_reg);
    assign nk_m1 = last_idx(inner_dim_reg);
    assign nc_m1 = last_idx(cols_second_reg);

    // input word
    assign in_op     = s_tuser;
    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[5:3];
    assign in_val    = s_tdata[21:6];
    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        wr_a  = 1'b0;
        wr_b  = 1'b0;
        start = 1'b0;
        if (in_accept) begin
            case (in_op)
                OP_WR_FIRST:  wr_a  = ({1'b0, in_row} < nr) && ({1'b0, in_col} < nk);
                OP_WR_SECOND: wr_b  = ({1'b0, in_row} < nk) && ({1'b0, in_col} < nc);
                OP_MULTIPLY:  start = 1'b1;
                default: ;
            endcase
        end
    end

    // walk sequencer
    assign adv   = !m_tvalid_reg || m_tready;
    assign issue = busy_reg && adv;
    assign k_end = (k_reg == nk_m1);
    assign j_end = (j_reg == nc_m1);
    assign i_end = (i_reg == nr_m1);

    always_comb begin
        busy_next = busy_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        if (start) begin
            busy_next = 1'b1;
            i_next    = '0;
            j_next    = '0;
            k_next    = '0;
        end else if (issue) begin
            k_next = k_end ? '0 : k_reg + IDX_W'(1);
            if (k_end) begin
                j_next = j_end ? '0 : j_reg + IDX_W'(1);
                if (j_end) begin
                    i_next = i_reg + IDX_W'(1);
                    if (i_end) begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    // element stores
    assign wr_addr   = elem_addr(in_row, in_col);
    assign rd_addr_a = elem_addr(i_reg, k_reg);
    assign rd_addr_b = elem_addr(k_reg, j_reg);

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            first_mem[wr_addr] <= in_val;
        end
        if (issue) begin
            a_rd_reg <= first_mem[rd_addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            second_mem[wr_addr] <= in_val;
        end
        if (issue) begin
            b_rd_reg <= second_mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_tag_reg.valid  <= issue;
            s1_tag_reg.first  <= (k_reg == '0);
            s1_tag_reg.last_k <= k_end;
            s1_tag_reg.row    <= i_reg;
            s1_tag_reg.col    <= j_reg;
            s1_tag_reg.last   <= k_end && j_end && i_end;
        end
    end

    imm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tag_in  (s1_tag_reg),
        .a_data  (a_rd_reg),
        .b_data  (b_rd_reg),
        .res     (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res.valid) begin
            out_row_reg <= res.row;
            out_col_reg <= res.col;
            out_val_reg <= res.value;
            m_tlast_reg <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {2'b00, out_val_reg, out_col_reg, out_row_reg};

    `IMM_ASSERT_NEXT(a_walk_ends, issue && k_end && j_end && i_end, !busy_reg)
    `IMM_ASSERT_NOW(a_no_write_in_walk, wr_a || wr_b, !issue && !busy_reg)
    `IMM_ASSERT_NOW(a_last_is_corner, m_tvalid && m_tlast,
                    out_row_reg == nr_m1 && out_col_reg == nc_m1)
    `IMM_ASSERT_NOW(a_result_has_room, res.valid && !adv, m_tvalid_reg && !m_tready)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import imm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] REG_NONE  = 2'd3;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] value;
        logic             last;
    } product_t;

    class matrix_product_model;
        logic [DIM_W-1:0]         dims [3];
        logic signed [ELEM_W-1:0] a_store [STORE_DEPTH];
        logic signed [ELEM_W-1:0] b_store [STORE_DEPTH];
        bit                       a_written [STORE_DEPTH];
        bit                       b_written [STORE_DEPTH];
        product_t                 expected_products [$];
        int                       n_writes;
        int                       n_ignored;
        int                       n_mults;
        int                       n_checked;
        int                       n_errors;

        function new();
            dims[0] = 4'd8;
            dims[1] = 4'd8;
            dims[2] = 4'd8;
        endfunction

        function int dim(int n);
            if (dims[n] == '0) begin
                return 1;
            end
            if (dims[n] > DIM_LIMIT) begin
                return DIM_LIMIT;
            end
            return int'(dims[n]);
        endfunction

        function int pending();
            return expected_products.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [DIM_W-1:0] v);
            case (idx)
                REG_ROWS_FIRST: begin
                    dims[0] = v;
                end
                REG_INNER_DIM: begin
                    dims[1] = v;
                end
                REG_COLS_SECOND: begin
                    dims[2] = v;
                end
                default: begin
                end
            endcase
        endfunction

        function void note_word(logic [1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic [ELEM_W-1:0] val);
            int nr;
            int nk;
            int nc;
            logic [SUM_W-1:0]        acc;
            logic signed [SUM_W-1:0] prod;
            product_t                p;
            nr = dim(0);
            nk = dim(1);
            nc = dim(2);
            case (op)
                OP_WR_FIRST: begin
                    if (row < nr && col < nk) begin
                        a_store[row * MAX_DIM + col] = val;
                        a_written[row * MAX_DIM + col] = 1'b1;
                        n_writes++;
                    end else begin
                        n_ignored++;
                    end
                end
                OP_WR_SECOND: begin
                    if (row < nk && col < nc) begin
                        b_store[row * MAX_DIM + col] = val;
                        b_written[row * MAX_DIM + col] = 1'b1;
                        n_writes++;
                    end else begin
                        n_ignored++;
                    end
                end
                OP_MULTIPLY: begin
                    n_mults++;
                    for (int i = 0; i < nr; i++) begin
                        for (int j = 0; j < nc; j++) begin
                            acc = '0;
                            for (int k = 0; k < nk; k++) begin
                                prod = a_store[i * MAX_DIM + k] * b_store[k * MAX_DIM + j];
                                acc = acc + prod;
                            end
                            p.row = IDX_W'(i);
                            p.col = IDX_W'(j);
                            p.value = acc;
                            p.last = (i == nr - 1) && (j == nc - 1);
                            expected_products.push_back(p);
                        end
                    end
                end
                default: begin
                    n_ignored++;
                end
            endcase
        endfunction

        function void report(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
            n_errors++;
            if (n_errors <= 40) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_word(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                 logic [SUM_W-1:0] value, logic last);
            product_t e;
            n_checked++;
            if (expected_products.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word, expected none, actual row %0d col %0d value %0h",
                         $time, row, col, value);
                return;
            end
            e = expected_products.pop_front();
            if (row !== e.row) begin
                report("out_row", SUM_W'(e.row), SUM_W'(row));
            end
            if (col !== e.col) begin
                report("out_col", SUM_W'(e.col), SUM_W'(col));
            end
            if (value !== e.value) begin
                report("product_value", e.value, value);
            end
            if (last !== e.last) begin
                report("last", SUM_W'(e.last), SUM_W'(last));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int send_idle_pct;
    int stall_pct;
    int n_settings;

    matrix_product_model board;

    integer_matrix_multiply_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_word(m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast);
        end
    end

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        if ($urandom_range(7) == 0) begin
            return DIM_W'($urandom_range(15));
        end
        return DIM_W'($urandom_range(1, 4));
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [1:0] op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, val, col, row};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        board.note_word(op, row, col, val);
        @(negedge aclk);
    endtask

    // drain results, then give trailing writes time to land
    task automatic settle();
        s_tvalid = 1'b0;
        while (board.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] v);
        cfg_index = idx;
        cfg_wdata = v;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.set_reg(idx, v);
    endtask

    task automatic new_setting(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                               input logic [DIM_W-1:0] c, input int mode);
        settle();
        write_reg(REG_ROWS_FIRST, r);
        write_reg(REG_INNER_DIM, k);
        write_reg(REG_COLS_SECOND, c);
        send_idle_pct = (mode == 1) ? 82 : (mode == 3) ? 22 : 0;
        stall_pct     = (mode == 2) ? 82 : (mode == 3) ? 22 : 0;
        n_settings++;
    endtask

    // every entry the multiply reads must have been written first
    task automatic multiply_now();
        int nr;
        int nk;
        int nc;
        nr = board.dim(0);
        nk = board.dim(1);
        nc = board.dim(2);
        for (int i = 0; i < nr; i++) begin
            for (int k = 0; k < nk; k++) begin
                if (!board.a_written[i * MAX_DIM + k]) begin
                    send_word(OP_WR_FIRST, IDX_W'(i), IDX_W'(k), rand_elem());
                end
            end
        end
        for (int k = 0; k < nk; k++) begin
            for (int j = 0; j < nc; j++) begin
                if (!board.b_written[k * MAX_DIM + j]) begin
                    send_word(OP_WR_SECOND, IDX_W'(k), IDX_W'(j), rand_elem());
                end
            end
        end
        send_word(OP_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
    endtask

    initial begin
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] k;
        logic [DIM_W-1:0] c;
        int               n_start;
        board = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        n_settings = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // row of most-negative A against a mostly most-negative column: sum wraps
        for (int i = 0; i < MAX_DIM; i++) begin
            send_word(OP_WR_FIRST, 3'd0, IDX_W'(i), 16'h8000);
        end
        for (int i = 0; i < MAX_DIM; i++) begin
            send_word(OP_WR_SECOND, IDX_W'(i), 3'd0, (i == MAX_DIM - 1) ? 16'h7fff : 16'h8000);
        end
        settle();
        write_reg(REG_ROWS_FIRST, 4'd1);
        write_reg(REG_COLS_SECOND, 4'd1);
        write_reg(REG_NONE, 4'hf);
        send_word(OP_MULTIPLY, 3'd0, 3'd0, 16'h0000);
        // out-of-size writes and the unused op must leave the stores alone
        send_word(OP_WR_FIRST, 3'd7, 3'd7, 16'h7fff);
        send_word(OP_WR_SECOND, 3'd3, 3'd5, 16'h1234);
        send_word(OP_UNUSED, 3'd7, 3'd7, 16'hffff);
        send_word(OP_MULTIPLY, 3'd7, 3'd7, 16'hffff);

        for (int p = 0; p < 8 || board.n_writes + board.n_mults < 320; p++) begin
            case (p)
                0: begin
                    r = 4'd2; k = 4'd3; c = 4'd2;
                end
                1: begin
                    r = 4'd1; k = 4'd1; c = 4'd1;
                end
                2: begin
                    r = 4'd15; k = 4'd9; c = 4'd0;
                end
                3: begin
                    r = 4'd0; k = 4'd15; c = 4'd8;
                end
                4: begin
                    r = 4'd8; k = 4'd8; c = 4'd8;
                end
                default: begin
                    r = rand_dim(); k = rand_dim(); c = rand_dim();
                end
            endcase
            new_setting(r, k, c, p % 4);
            n_start = board.n_writes + board.n_mults;
            while (board.n_writes + board.n_mults - n_start < 30) begin
                repeat ($urandom_range(6)) begin
                    if ($urandom_range(1) == 0) begin
                        send_word(OP_WR_FIRST, IDX_W'($urandom_range(board.dim(0) - 1)),
                                  IDX_W'($urandom_range(board.dim(1) - 1)), rand_elem());
                    end else begin
                        send_word(OP_WR_SECOND, IDX_W'($urandom_range(board.dim(1) - 1)),
                                  IDX_W'($urandom_range(board.dim(2) - 1)), rand_elem());
                    end
                end
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(2))
                        0: send_word(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
                        1: send_word(OP_WR_FIRST, IDX_W'($urandom), IDX_W'($urandom),
                                     rand_elem());
                        default: send_word(OP_WR_SECOND, IDX_W'($urandom), IDX_W'($urandom),
                                           rand_elem());
                    endcase
                end
                multiply_now();
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        $display("Checked %0d product words from %0d multiplies, %0d element writes, %0d ignored.",
                 board.n_checked, board.n_mults, board.n_writes, board.n_ignored);
        $display("Ran %0d size settings, including clamped ones, with and without backpressure.",
                 n_settings);
        if (board.n_errors == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d product words outstanding", board.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
